[rtl/core/wpd_pkg.sv]
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types, codes and constants of the weighted pose distance block.
// ----------------------------------------------------------------------------
package wpd_pkg;

  localparam int STEP_W       = 5;
  localparam int CFG_INDEX_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_TRANSLATION_WEIGHT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_WEIGHT    = 8'd1;

  localparam logic [15:0] TRANSLATION_WEIGHT_RESET = 16'd2048;
  localparam logic [15:0] ROTATION_WEIGHT_RESET    = 16'd2867;

  localparam logic [STEP_W-1:0] SQ_LAST     = 5'd6;
  localparam logic [STEP_W-1:0] SQRT_LAST   = 5'd31;
  localparam logic [STEP_W-1:0] TD_LAST     = 5'd1;
  localparam logic [STEP_W-1:0] DOT_LAST    = 5'd4;
  localparam logic [STEP_W-1:0] IDX_LAST    = 5'd2;
  localparam logic [STEP_W-1:0] RD_LAST     = 5'd1;
  localparam logic [STEP_W-1:0] CSQ_LAST    = 5'd2;
  localparam logic [STEP_W-1:0] CORDIC_LAST = 5'd16;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_SQRT,
    OP_TD,
    OP_DOT,
    OP_IDX,
    OP_RD,
    OP_SUM,
    OP_FINIT,
    OP_CSQ,
    OP_CINIT,
    OP_CORDIC,
    OP_FILLW
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic emit_wanted;
    logic out_busy;
  } sts_t;

  function automatic logic [15:0] cordic_atan(input logic [STEP_W-1:0] i);
    logic [15:0] a;
    case (i)
      5'd0:    a = 16'd51472;
      5'd1:    a = 16'd30386;
      5'd2:    a = 16'd16055;
      5'd3:    a = 16'd8150;
      5'd4:    a = 16'd4091;
      5'd5:    a = 16'd2047;
      5'd6:    a = 16'd1024;
      5'd7:    a = 16'd512;
      5'd8:    a = 16'd256;
      5'd9:    a = 16'd128;
      5'd10:   a = 16'd64;
      5'd11:   a = 16'd32;
      5'd12:   a = 16'd16;
      5'd13:   a = 16'd8;
      5'd14:   a = 16'd4;
      5'd15:   a = 16'd2;
      5'd16:   a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

[rtl/core/wpd_ram.sv]
// ----------------------------------------------------------------------------
// wpd_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module wpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/wpd_datapath.sv]
// ----------------------------------------------------------------------------
// wpd_datapath
// Held pose, shared multiplier, square root and CORDIC steps, arccos table
// and the saturating distance sum.
// ----------------------------------------------------------------------------
module wpd_datapath #(
  parameter int ARCCOS_TABLE_DEPTH = 256,
  parameter int MAX_BODIES         = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wpd_pkg::cmd_t                    cmd,
  output wpd_pkg::sts_t                    sts,
  input  logic signed [31:0]               pos_x,
  input  logic signed [31:0]               pos_y,
  input  logic signed [31:0]               pos_z,
  input  logic signed [15:0]               quat_w,
  input  logic signed [15:0]               quat_x,
  input  logic signed [15:0]               quat_y,
  input  logic signed [15:0]               quat_z,
  input  logic                             second_pose,
  input  logic                             last_body,
  input  logic                             cfg_valid,
  input  logic [wpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [15:0]                      cfg_data,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [31:0]                      pose_distance
);
  import wpd_pkg::*;

  localparam int AW     = $clog2(ARCCOS_TABLE_DEPTH);
  localparam int PCW    = $clog2(MAX_BODIES + 1);
  localparam int C_STEP = (1 << 30) / (ARCCOS_TABLE_DEPTH - 1);
  localparam int C_REM  = (1 << 30) % (ARCCOS_TABLE_DEPTH - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ARCCOS_TABLE_DEPTH - 1);

  logic [15:0]        tw;
  logic [15:0]        rw;
  logic [31:0]        held_pos [3];
  logic [15:0]        held_q [4];
  logic [15:0]        in_q [4];
  logic               last_flag;
  logic [30:0]        v [3];
  logic               sh;
  logic [63:0]        acc;
  logic [63:0]        root;
  logic signed [51:0] prod;
  logic [37:0]        td;
  logic signed [34:0] dot;
  logic [AW-1:0]      idx;
  logic [21:0]        rd;
  logic [31:0]        sum;
  logic [PCW-1:0]     pair_count;
  logic [30:0]        c;
  logic [AW-1:0]      crem;
  logic [AW-1:0]      faddr;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [18:0] cz;

  logic [31:0]        in_pos [3];
  logic [15:0]        in_quat [4];
  logic [31:0]        mag [3];
  logic signed [33:0] ma;
  logic signed [17:0] mb;
  logic [51:0]        pr_u;
  logic [30:0]        vpick;
  logic [34:0]        dabs;
  logic [30:0]        cabs;
  logic [63:0]        bitv;
  logic [63:0]        trial;
  logic [51:0]        rnd;
  logic [21:0]        qidx;
  logic [38:0]        total;
  logic [31:0]        total_sat;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [18:0] at;
  logic [18:0]        zr;
  logic [15:0]        zout;
  logic [AW:0]        crem_sum;
  logic [15:0]        ram_q;
  logic               emit_now;

  function automatic logic signed [33:0] shr_tz(input logic signed [33:0] a,
                                                input logic [STEP_W-1:0] n);
    logic [33:0] m;
    m = a[33] ? 34'(-a) : 34'(a);
    m = m >> n;
    return a[33] ? -$signed(m) : $signed(m);
  endfunction

  assign in_pos[0]  = pos_x;
  assign in_pos[1]  = pos_y;
  assign in_pos[2]  = pos_z;
  assign in_quat[0] = quat_w;
  assign in_quat[1] = quat_x;
  assign in_quat[2] = quat_y;
  assign in_quat[3] = quat_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [32:0] ds;
      ds     = $signed({held_pos[i][31], held_pos[i]}) - $signed({in_pos[i][31], in_pos[i]});
      mag[i] = ds[32] ? 32'(-ds) : ds[31:0];
    end
  end

  always_comb begin
    case (cmd.step[2:1])
      2'd0:    vpick = v[0];
      2'd1:    vpick = v[1];
      2'd2:    vpick = v[2];
      default: vpick = '0;
    endcase
  end

  assign dabs = dot[34] ? 35'(-dot) : 35'(dot);
  assign cabs = (dabs > 35'd1073741824) ? 31'd1073741824 : dabs[30:0];

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_SQ: begin
        ma = $signed({3'b0, vpick});
        mb = cmd.step[0] ? $signed({3'b0, vpick[30:16]}) : $signed({2'b0, vpick[15:0]});
      end
      OP_CSQ: begin
        ma = $signed({3'b0, c});
        mb = cmd.step[0] ? $signed({3'b0, c[30:16]}) : $signed({2'b0, c[15:0]});
      end
      OP_TD: begin
        ma = $signed({1'b0, (sh ? {root[31:0], 1'b0} : {1'b0, root[31:0]})});
        mb = $signed({2'b0, tw});
      end
      OP_DOT: begin
        ma = $signed({{18{held_q[cmd.step[1:0]][15]}}, held_q[cmd.step[1:0]]});
        mb = $signed({{2{in_q[cmd.step[1:0]][15]}}, in_q[cmd.step[1:0]]});
      end
      OP_IDX: begin
        ma = $signed({3'b0, cabs});
        mb = $signed(18'(ARCCOS_TABLE_DEPTH - 1));
      end
      OP_RD: begin
        ma = $signed({18'b0, ram_q});
        mb = $signed({2'b0, rw});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign pr_u  = prod;
  assign bitv  = 64'h4000_0000_0000_0000 >> {cmd.step, 1'b0};
  assign trial = root + bitv;
  assign qidx  = rnd[51:30];

  always_comb begin
    rnd = '0;
    case (cmd.op)
      OP_TD:   rnd = pr_u + 52'd2048;
      OP_IDX:  rnd = pr_u + 52'd536870912;
      OP_RD:   rnd = pr_u + 52'd1024;
      default: rnd = pr_u;
    endcase
  end

  assign total     = {7'b0, sum} + {1'b0, td} + {17'b0, rd};
  assign total_sat = (total > 39'h00FFFFFFFF) ? 32'hFFFF_FFFF : total[31:0];

  assign xs = shr_tz(cx, cmd.step);
  assign ys = shr_tz(cy, cmd.step);
  assign at = $signed({3'b0, cordic_atan(cmd.step)});

  always_comb begin
    logic [18:0] zc;
    zc   = cz[18] ? 19'd0 : 19'(cz);
    zr   = (zc + 19'd1) >> 1;
    zout = (zr > 19'd65535) ? 16'hFFFF : zr[15:0];
  end

  assign crem_sum = {1'b0, crem} + (AW + 1)'(C_REM);

  assign sts.fill_last   = (faddr == LAST_ADDR);
  assign sts.emit_wanted = last_flag || (pair_count == PCW'(MAX_BODIES - 1));
  assign sts.out_busy    = out_valid && out_stall;
  assign emit_now        = (cmd.op == OP_SUM) && sts.emit_wanted;

  wpd_ram #(
    .WIDTH (16),
    .DEPTH (ARCCOS_TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.op == OP_FILLW),
    .wr_addr (faddr),
    .wr_data (zout),
    .rd_en   ((cmd.op == OP_IDX) && (cmd.step == IDX_LAST)),
    .rd_addr (idx),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tw <= TRANSLATION_WEIGHT_RESET;
      rw <= ROTATION_WEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TRANSLATION_WEIGHT: tw <= cfg_data;
        REG_ROTATION_WEIGHT:    rw <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) held_pos[i] <= '0;
      for (int i = 0; i < 4; i++) held_q[i] <= '0;
      sum        <= '0;
      pair_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.op == OP_LOAD && !second_pose) begin
        for (int i = 0; i < 3; i++) held_pos[i] <= in_pos[i];
        for (int i = 0; i < 4; i++) held_q[i] <= in_quat[i];
      end
      if (cmd.op == OP_SUM) begin
        if (sts.emit_wanted) begin
          sum        <= '0;
          pair_count <= '0;
        end else begin
          sum        <= total_sat;
          pair_count <= pair_count + PCW'(1);
        end
      end
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (emit_now) begin
      pose_distance <= total_sat;
    end
    case (cmd.op)
      OP_LOAD: begin
        for (int i = 0; i < 4; i++) in_q[i] <= in_quat[i];
        last_flag <= last_body;
        sh        <= mag[0][31] | mag[1][31] | mag[2][31];
        for (int i = 0; i < 3; i++) begin
          v[i] <= (mag[0][31] | mag[1][31] | mag[2][31]) ? mag[i][31:1] : mag[i][30:0];
        end
        acc  <= '0;
        root <= '0;
      end
      OP_SQ: begin
        if (cmd.step != 5'd0) begin
          acc <= acc + ({12'b0, pr_u} << (cmd.step[0] ? 0 : 16));
        end
      end
      OP_CSQ: begin
        case (cmd.step)
          5'd0:    begin
            acc  <= 64'h1000_0000_0000_0000;
            root <= '0;
          end
          5'd1:    acc <= acc - {12'b0, pr_u};
          default: acc <= acc - ({12'b0, pr_u} << 16);
        endcase
      end
      OP_SQRT: begin
        if (acc >= trial) begin
          acc  <= acc - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
      end
      OP_TD: begin
        if (cmd.step == TD_LAST) td <= rnd[49:12];
      end
      OP_DOT: begin
        if (cmd.step == 5'd0) begin
          dot <= '0;
        end else begin
          dot <= dot + $signed(prod[34:0]);
        end
      end
      OP_IDX: begin
        if (cmd.step == 5'd1) begin
          idx <= (qidx > 22'(ARCCOS_TABLE_DEPTH - 1)) ? LAST_ADDR : qidx[AW-1:0];
        end
      end
      OP_RD: begin
        if (cmd.step == RD_LAST) rd <= rnd[32:11];
      end
      OP_FINIT: begin
        c     <= '0;
        crem  <= '0;
        faddr <= '0;
      end
      OP_CINIT: begin
        cx <= $signed({3'b0, c});
        cy <= $signed({2'b0, root[31:0]});
        cz <= '0;
      end
      OP_CORDIC: begin
        if (!cy[33]) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end
      end
      OP_FILLW: begin
        faddr <= faddr + AW'(1);
        if (crem_sum >= (AW + 1)'(ARCCOS_TABLE_DEPTH - 1)) begin
          crem <= AW'(crem_sum - (AW + 1)'(ARCCOS_TABLE_DEPTH - 1));
          c    <= c + 31'(C_STEP) + 31'd1;
        end else begin
          crem <= crem_sum[AW-1:0];
          c    <= c + 31'(C_STEP);
        end
      end
      default: ;
    endcase
  end

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit_now |=> (sum == '0) && (pair_count == '0) && out_valid)
    else $error("sum not cleared after a result");

  a_pair_bound: assert property (@(posedge clk) disable iff (rst)
    pair_count < PCW'(MAX_BODIES))
    else $error("pair count beyond body limit");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_IDX && cmd.step == IDX_LAST) |-> (idx <= LAST_ADDR))
    else $error("table index out of range");

endmodule

[rtl/core/wpd_ctrl.sv]
// ----------------------------------------------------------------------------
// wpd_ctrl
// Sequencer for the table fill after reset and for each pose pair.
// ----------------------------------------------------------------------------
module wpd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          second_pose,
  output logic          in_stall,
  output wpd_pkg::cmd_t cmd,
  input  wpd_pkg::sts_t sts
);
  import wpd_pkg::*;

  typedef enum logic [3:0] {
    S_FINIT,
    S_CSQ,
    S_FSQRT,
    S_CINIT,
    S_CORDIC,
    S_FILLW,
    S_IDLE,
    S_SQ,
    S_SQRT,
    S_TD,
    S_DOT,
    S_IDX,
    S_RD,
    S_SUM
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  always_comb begin
    state_next = state;
    step_next  = step + STEP_W'(1);
    cmd.op     = OP_NONE;
    cmd.step   = step;
    in_stall   = (state != S_IDLE);
    case (state)
      S_FINIT: begin
        cmd.op     = OP_FINIT;
        state_next = S_CSQ;
        step_next  = '0;
      end
      S_CSQ: begin
        cmd.op = OP_CSQ;
        if (step == CSQ_LAST) begin
          state_next = S_FSQRT;
          step_next  = '0;
        end
      end
      S_FSQRT: begin
        cmd.op = OP_SQRT;
        if (step == SQRT_LAST) begin
          state_next = S_CINIT;
          step_next  = '0;
        end
      end
      S_CINIT: begin
        cmd.op     = OP_CINIT;
        state_next = S_CORDIC;
        step_next  = '0;
      end
      S_CORDIC: begin
        cmd.op = OP_CORDIC;
        if (step == CORDIC_LAST) begin
          state_next = S_FILLW;
          step_next  = '0;
        end
      end
      S_FILLW: begin
        cmd.op     = OP_FILLW;
        state_next = sts.fill_last ? S_IDLE : S_CSQ;
        step_next  = '0;
      end
      S_IDLE: begin
        step_next = '0;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (second_pose) state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (step == SQ_LAST) begin
          state_next = S_SQRT;
          step_next  = '0;
        end
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (step == SQRT_LAST) begin
          state_next = S_TD;
          step_next  = '0;
        end
      end
      S_TD: begin
        cmd.op = OP_TD;
        if (step == TD_LAST) begin
          state_next = S_DOT;
          step_next  = '0;
        end
      end
      S_DOT: begin
        cmd.op = OP_DOT;
        if (step == DOT_LAST) begin
          state_next = S_IDX;
          step_next  = '0;
        end
      end
      S_IDX: begin
        cmd.op = OP_IDX;
        if (step == IDX_LAST) begin
          state_next = S_RD;
          step_next  = '0;
        end
      end
      S_RD: begin
        cmd.op = OP_RD;
        if (step == RD_LAST) begin
          state_next = S_SUM;
          step_next  = '0;
        end
      end
      S_SUM: begin
        step_next = '0;
        if (!(sts.emit_wanted && sts.out_busy)) begin
          cmd.op     = OP_SUM;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FINIT;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

[rtl/core/weighted_pose_distance.sv]
// ----------------------------------------------------------------------------
// weighted_pose_distance
// Weighted translational and rotational distance between two multi-body poses.
// ----------------------------------------------------------------------------
// A first pose is taken and held. A second pose is worked through the
// bit-serial square root and the shared multiplier, which forms the squares,
// the weightings, the quaternion dot product and the table index one product
// per cycle; the input stalls meanwhile. After reset the arccos table is
// filled by the same square root and a 17-step CORDIC, and no item is taken
// until the table is full; configuration writes are taken at any time. A
// finished sum waits in an output register while the next pair is worked on.
module weighted_pose_distance #(
  parameter int ARCCOS_TABLE_DEPTH = 256,
  parameter int MAX_BODIES         = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [31:0]              pos_x,
  input  logic signed [31:0]              pos_y,
  input  logic signed [31:0]              pos_z,
  input  logic signed [15:0]              quat_w,
  input  logic signed [15:0]              quat_x,
  input  logic signed [15:0]              quat_y,
  input  logic signed [15:0]              quat_z,
  input  logic                            second_pose,
  input  logic                            last_body,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [31:0]                     pose_distance,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);
  import wpd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  wpd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .second_pose (second_pose),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  wpd_datapath #(
    .ARCCOS_TABLE_DEPTH (ARCCOS_TABLE_DEPTH),
    .MAX_BODIES         (MAX_BODIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .quat_w        (quat_w),
    .quat_x        (quat_x),
    .quat_y        (quat_y),
    .quat_z        (quat_z),
    .second_pose   (second_pose),
    .last_body     (last_body),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .pose_distance (pose_distance)
  );

endmodule

[tb/sv/weighted_pose_distance_tb.sv]
// ----------------------------------------------------------------------------
// weighted_pose_distance_tb
// Drives pose pairs with random gaps and output stalls, predicts each
// accumulated distance with a bit-exact integer model and checks every
// emitted sum in order. Weights are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module weighted_pose_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wpd_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int BODY_LIMIT  = 8;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [15:0] qw, qx, qy, qz;
    logic        second, last;
  } pose_t;

  class distance_board;
    logic [31:0] sums[$];
    int          mismatches;
    logic [15:0] t_weight, r_weight;
    logic [31:0] held_pos[3];
    logic [15:0] held_quat[4];
    logic [31:0] running;
    int          pairs;
    logic [15:0] acos_lut[TABLE_DEPTH];

    function longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint rshift_sym(longint v, int n);
      if (v >= 0) return v >>> n;
      return -((-v) >>> n);
    endfunction

    function logic [15:0] arccos_q15(longint c);
      longint x, y, z, xs, ys;
      x = c;
      y = longint'(root64((64'd1 << 60) - longint'(c * c)));
      z = 0;
      for (int i = 0; i < 17; i++) begin
        xs = rshift_sym(x, i);
        ys = rshift_sym(y, i);
        if (y >= 0) begin
          x += ys; y -= xs; z += cordic_atan(i[4:0]);
        end else begin
          x -= ys; y += xs; z -= cordic_atan(i[4:0]);
        end
      end
      if (z < 0) z = 0;
      z = (z + 1) >>> 1;
      if (z > 65535) z = 65535;
      return z[15:0];
    endfunction

    function new();
      t_weight = TRANSLATION_WEIGHT_RESET;
      r_weight = ROTATION_WEIGHT_RESET;
      foreach (held_pos[i]) held_pos[i] = 0;
      foreach (held_quat[i]) held_quat[i] = 0;
      running = 0;
      pairs = 0;
      mismatches = 0;
      for (int k = 0; k < TABLE_DEPTH; k++)
        acos_lut[k] = arccos_q15(longint'((64'(k) << 30) / (TABLE_DEPTH - 1)));
    endfunction

    function void note_input(pose_t p);
      longint          d[3], dot, cabs;
      longint unsigned sq, rt, td, rd, idx, total;
      logic [31:0]     pin[3];
      logic [15:0]     qin[4];
      int              sh;
      pin = '{p.px, p.py, p.pz};
      qin = '{p.qw, p.qx, p.qy, p.qz};
      if (!p.second) begin
        held_pos = pin;
        held_quat = qin;
        return;
      end
      sh = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = longint'($signed(held_pos[i])) - longint'($signed(pin[i]));
        if (d[i] < 0) d[i] = -d[i];
        if (d[i] >= 64'sd2147483648) sh = 1;
      end
      sq = 0;
      for (int i = 0; i < 3; i++) sq += (d[i] >> sh) * (d[i] >> sh);
      rt = root64(sq) << sh;
      td = (rt * t_weight + 2048) >> 12;
      dot = 0;
      for (int i = 0; i < 4; i++)
        dot += longint'($signed(held_quat[i])) * longint'($signed(qin[i]));
      cabs = dot < 0 ? -dot : dot;
      if (cabs > (64'sd1 << 30)) cabs = 64'sd1 << 30;
      idx = (cabs * (TABLE_DEPTH - 1) + (64'd1 << 29)) >> 30;
      if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
      rd = (64'(acos_lut[idx]) * r_weight + 1024) >> 11;
      total = 64'(running) + td + rd;
      if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
      running = total[31:0];
      pairs++;
      if (p.last || pairs >= BODY_LIMIT) begin
        sums.push_back(running);
        running = 0;
        pairs = 0;
      end
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose_distance %h", got);
        return;
      end
      want = sums.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pose_distance mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
  logic signed [15:0] quat_w = 0, quat_x = 0, quat_y = 0, quat_z = 0;
  logic second_pose = 0, last_body = 0;
  logic [31:0] pose_distance;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  distance_board board;
  int cycles = 0;
  bit long_hold = 0;

  always #2 clk = ~clk;

  weighted_pose_distance u_dut (
    .clk, .rst, .in_valid, .in_stall, .pos_x, .pos_y, .pos_z,
    .quat_w, .quat_x, .quat_y, .quat_z, .second_pose, .last_body,
    .out_valid, .out_stall, .pose_distance,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) board.check_result(pose_distance);

  // Receiver: random stall lengths per result, plus one long hold-off.
  initial begin
    int gap;
    @(posedge clk);
    while (1) begin
      if (long_hold) begin
        out_stall <= 1;
        repeat (3000) @(posedge clk);
        long_hold = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      out_stall <= (gap != 0);
      repeat (gap) @(posedge clk);
      out_stall <= 0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == REG_TRANSLATION_WEIGHT) board.t_weight = val;
    else board.r_weight = val;
  endtask

  task automatic send_pose(pose_t p, bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
    quat_w <= p.qw; quat_x <= p.qx; quat_y <= p.qy; quat_z <= p.qz;
    second_pose <= p.second; last_body <= p.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(p);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.sums.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 65535 * 16))
                                     : -32'($urandom_range(0, 65535 * 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pose_t rand_pose(bit second, bit last);
    pose_t p;
    p.px = rand_pos(); p.py = rand_pos(); p.pz = rand_pos();
    p.qw = rand_q(); p.qx = rand_q(); p.qy = rand_q(); p.qz = rand_q();
    p.second = second;
    p.last = last;
    return p;
  endfunction

  function automatic pose_t fixed_pose(logic [31:0] v, logic [15:0] q, bit s, bit l);
    pose_t p;
    p.px = v; p.py = v; p.pz = v;
    p.qw = q; p.qx = q; p.qy = q; p.qz = q;
    p.second = s; p.last = l;
    return p;
  endfunction

  initial begin
    int bodies;
    logic [15:0] wt[4];
    board = new();
    repeat (11) @(posedge clk);
    rst <= 0;

    // Directed part: second pose against reset state, last mark on a first
    // pose, repeated first pose, extreme positions and quaternions, body limit.
    send_pose(fixed_pose(32'h7FFF_FFFF, 16'h7FFF, 1, 1), 0);
    send_pose(fixed_pose(32'h8000_0000, 16'h8000, 0, 1), 0);
    send_pose(fixed_pose(32'h1234_5678, 16'h4000, 0, 0), 0);
    send_pose(fixed_pose(32'h7FFF_FFFF, 16'h7FFF, 1, 1), 0);
    send_pose(fixed_pose(32'h0000_0000, 16'h5A82, 0, 0), 0);
    send_pose(fixed_pose(32'h0000_0000, 16'hA57E, 1, 0), 0);
    send_pose(fixed_pose(32'hFFFF_FFFF, 16'h0000, 1, 1), 0);
    for (int i = 0; i < 9; i++)
      send_pose(fixed_pose(32'h8000_0000 + i, 16'h8000, 1, 0), 0);
    drain();

    wt = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000};
    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 4) begin
        write_reg(REG_TRANSLATION_WEIGHT, wt[phase]);
        write_reg(REG_ROTATION_WEIGHT, wt[3 - phase]);
      end else begin
        write_reg(REG_TRANSLATION_WEIGHT, 16'($urandom));
        write_reg(REG_ROTATION_WEIGHT, 16'($urandom));
      end
      if (phase == 2) long_hold = 1;
      for (int n = 0; n < 280; ) begin
        if ($urandom_range(0, 9) == 0) begin
          send_pose(rand_pose(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                    phase == 2);
          n++;
        end else begin
          bodies = $urandom_range(1, 9);
          for (int b = 0; b < bodies; b++) begin
            send_pose(rand_pose(0, $urandom_range(0, 7) == 0), phase == 2);
            send_pose(rand_pose(1, b == bodies - 1), phase == 2);
            n += 2;
          end
        end
      end
      drain();
    end

    if (board.mismatches == 0 && board.sums.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/wpd_pkg.sv
rtl/core/wpd_ram.sv
rtl/core/wpd_datapath.sv
rtl/core/wpd_ctrl.sv
rtl/core/weighted_pose_distance.sv
tb/sv/weighted_pose_distance_tb.sv
